>>> hdl/wipa_pkg.sv
package wipa_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] RegQuantity = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegNormMode = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegPlanar   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegAvgU     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegAvgV     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegAvgW     = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegAvgP     = 3'd6;

  localparam logic [2:0] QtyU  = 3'd0;
  localparam logic [2:0] QtyV  = 3'd1;
  localparam logic [2:0] QtyW  = 3'd2;
  localparam logic [2:0] QtyP  = 3'd3;
  localparam logic [2:0] QtyKe = 3'd4;
  localparam logic [2:0] QtyQ  = 3'd5;

  localparam logic [1:0] NormNone   = 2'd0;
  localparam logic [1:0] NormLocal  = 2'd1;
  localparam logic [1:0] NormGlobal = 2'd2;

  localparam logic [15:0] AvgReset = 16'd4096;

  typedef struct packed {
    logic signed [SampleWidth-1:0] a_u;
    logic signed [SampleWidth-1:0] a_v;
    logic signed [SampleWidth-1:0] a_w;
    logic signed [SampleWidth-1:0] a_p;
    logic signed [SampleWidth-1:0] b_u;
    logic signed [SampleWidth-1:0] b_v;
    logic signed [SampleWidth-1:0] b_w;
    logic signed [SampleWidth-1:0] b_p;
    logic [63:0]                   rms_packed;
    logic [31:0]                   cell_volume;
    logic                          last_point;
  } point_t;

  typedef struct packed {
    logic signed [63:0] dot_sum;
    logic               saturated;
    logic               zero_divisor;
  } result_t;

  // configuration snapshot taken with each point
  typedef struct packed {
    logic [2:0]  quantity;
    logic [1:0]  norm_mode;
    logic        planar_mode;
    logic [15:0] avg_u;
    logic [15:0] avg_v;
    logic [15:0] avg_w;
    logic [15:0] avg_p;
  } cfg_t;

  typedef struct packed {
    point_t pt;
    cfg_t   cfg;
    logic   valid_combo;
  } job_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    mag64 = x[63] ? (64'd0 - 64'(x)) : 64'(x);
  endfunction

  // saturating signed add, returns {sat, sum}
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic [63:0] r;
    r = 64'(a) + 64'(b);
    if (a[63] == b[63] && r[63] != a[63]) begin
      sat_add = {1'b1, a[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff};
    end else begin
      sat_add = {1'b0, r};
    end
  endfunction

  // magnitude (128 bits) plus sign to signed 64 with saturation, returns {sat, value}
  function automatic logic [64:0] to_signed(input logic [127:0] m, input logic neg);
    logic [63:0] top;
    top = 64'h8000_0000_0000_0000;
    if (m[127:64] != 64'd0 || m[63:0] > top || (!neg && m[63:0] == top)) begin
      to_signed = {1'b1, neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff};
    end else begin
      to_signed = {1'b0, neg ? (64'd0 - m[63:0]) : m[63:0]};
    end
  endfunction

endpackage

>>> hdl/wipa_stream_if.sv
interface wipa_stream_if #(type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/weighted_inner_product_accumulator.sv
// channel   dir  payload                                   handshake
// in_s      in   a_u..b_p, rms_packed, cell_volume, last   valid/ready
// out_s     out  dot_sum, saturated, zero_divisor          valid/ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i           write enable only
//
// each term of a point runs through the 4-step shared multiplier; local division
// also passes each term through the 128-step divider (skipped on a zero divisor),
// while q with local normalisation multiplies twice per half instead; global mode
// divides each component at the last point, and the result beat waits for out_s ready.
// reset clears sums, flags and config to reset values.
// a two-entry queue lets the front accept while the back end works or stalls.
module weighted_inner_product_accumulator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  wipa_stream_if.sink                        in_s,
  wipa_stream_if.source                      out_s,
  input  logic                               cfg_we_i,
  input  logic [wipa_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [wipa_pkg::CfgWidth-1:0]      cfg_data_i
);
  import wipa_pkg::*;

  cfg_t cfg_q;
  logic job_valid, deq;
  job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{quantity: QtyU, norm_mode: NormNone, planar_mode: 1'b0,
                 avg_u: AvgReset, avg_v: AvgReset, avg_w: AvgReset, avg_p: AvgReset};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegQuantity: cfg_q.quantity    <= cfg_data_i[2:0];
        RegNormMode: cfg_q.norm_mode   <= cfg_data_i[1:0];
        RegPlanar:   cfg_q.planar_mode <= cfg_data_i[0];
        RegAvgU:     cfg_q.avg_u       <= cfg_data_i;
        RegAvgV:     cfg_q.avg_v       <= cfg_data_i;
        RegAvgW:     cfg_q.avg_w       <= cfg_data_i;
        RegAvgP:     cfg_q.avg_p       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wipa_front u_front (
    .clk_i, .rst_ni, .in_s, .cfg_i(cfg_q), .deq_i(deq),
    .job_valid_o(job_valid), .job_o(job)
  );

  wipa_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .deq_o(deq), .out_s
  );
endmodule

>>> hdl/wipa_mul.sv
// sequential 64x64 multiplier, 32x32 partial product per cycle
module wipa_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);
  import wipa_pkg::*;

  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic         busy_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] sh;

  always_comb begin
    pa = step_q[1] ? a_q[63:32] : a_q[31:0];
    pb = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp = 64'(pa) * 64'(pb);
    sh = 128'(pp) << ((7'(step_q[1]) + 7'(step_q[0])) * 7'd32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 3'd0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd0;
      end else if (busy_q) begin
        if (step_q == 3'd3) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + sh;
    end
  end

  assign p_o = acc_q;
endmodule

>>> hdl/wipa_div.sv
// restoring divider, one quotient bit per cycle: (m << s) / d, 128-bit quotient
module wipa_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  m_i,
  input  logic [63:0]  d_i,
  input  logic [4:0]   s_i,
  output logic         done_o,
  output logic [127:0] q_o
);
  import wipa_pkg::*;

  logic [127:0] n_q;
  logic [63:0]  d_q, r_q;
  logic [6:0]   cnt_q;
  logic         busy_q;
  logic [64:0]  r_sh;
  logic         ge;

  always_comb begin
    r_sh = {r_q, n_q[127]};
    ge   = r_sh >= 65'(d_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into n_q as dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= 128'(m_i) << s_i;
      d_q <= d_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= ge ? 64'(r_sh - 65'(d_q)) : r_sh[63:0];
      n_q <= {n_q[126:0], ge};
    end
  end

  assign q_o = n_q;
endmodule

>>> hdl/wipa_front.sv
// accepts points, snapshots config, classifies, two-entry queue to the back end
module wipa_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  wipa_stream_if.sink    in_s,
  input  wipa_pkg::cfg_t cfg_i,
  input  logic           deq_i,
  output logic           job_valid_o,
  output wipa_pkg::job_t job_o
);
  import wipa_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       vld;
  logic       enq;

  assign in_s.ready = cnt_q != 2'd2;
  assign enq        = in_s.valid && in_s.ready;

  always_comb begin
    vld = cfg_i.quantity <= QtyQ && cfg_i.norm_mode <= NormGlobal &&
          !(cfg_i.quantity == QtyW && cfg_i.planar_mode) &&
          !(cfg_i.norm_mode == NormGlobal && cfg_i.quantity < QtyKe);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (enq) wr_q <= !wr_q;
      if (deq_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(enq) - 2'(deq_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) mem_q[wr_q] <= '{pt: in_s.data, cfg: cfg_i, valid_combo: vld};
  end

  assign job_valid_o = cnt_q != 2'd0;
  assign job_o       = mem_q[rd_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !enq) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_i |-> cnt_q != 2'd0) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("count out of range");
`endif
endmodule

>>> hdl/wipa_back.sv
// sequencer: products, normalisation, accumulation, final global pass
module wipa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  wipa_pkg::job_t job_i,
  output logic           deq_o,
  wipa_stream_if.source  out_s
);
  import wipa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TERM, S_MUL1W, S_MUL2, S_MUL2W, S_DIV, S_DIVW, S_ADD, S_NEXT,
    S_FIN, S_FDIV, S_FDIVW, S_OUT
  } state_e;

  state_e state_q;
  job_t   job_q;
  logic signed [63:0] total_q, res_q, x_q;
  logic signed [63:0] comp_q [4];
  logic [1:0] flags_q;
  logic [1:0] c_q;     // component index
  logic [1:0] last_c_q;
  logic       qpart_q; // q-local: second half
  logic       mstart, mdone, dstart, ddone;
  logic [63:0]  ma, mb, dm, dd;
  logic [4:0]   ds;
  logic [127:0] mp, dq;
  logic signed [63:0] prod [4];
  logic [31:0] r2 [4];
  logic [31:0] a2 [4];
  logic [15:0] avg [4];
  logic [64:0] sv, av, tv;
  logic [64:0] cv, fv, rv;
  logic [127:0] msh;
  logic signed [63:0] mul_in;
  logic [63:0] mul_y;
  logic [4:0]  mul_s;
  logic [64:0] s3a, s3b;
  logic [33:0] r2sum;

  wipa_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .done_o(mdone), .p_o(mp)
  );
  wipa_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .m_i(dm), .d_i(dd), .s_i(ds), .done_o(ddone),
    .q_o(dq)
  );

  always_comb begin
    avg[0] = job_q.cfg.avg_u;
    avg[1] = job_q.cfg.avg_v;
    avg[2] = job_q.cfg.avg_w;
    avg[3] = job_q.cfg.avg_p;
    prod[0] = 64'(job_q.pt.a_u) * 64'(job_q.pt.b_u);
    prod[1] = 64'(job_q.pt.a_v) * 64'(job_q.pt.b_v);
    prod[2] = 64'(job_q.pt.a_w) * 64'(job_q.pt.b_w);
    prod[3] = 64'(job_q.pt.a_p) * 64'(job_q.pt.b_p);
    for (int i = 0; i < 4; i++) begin
      r2[i] = 32'(job_q.pt.rms_packed[16*i +: 16]) * 32'(job_q.pt.rms_packed[16*i +: 16]);
      a2[i] = 32'(avg[i]) * 32'(avg[i]);
    end
    r2sum = 34'(r2[0]) + 34'(r2[1]) + 34'(r2[2]);
    s3a = sat_add(prod[0], prod[1]);
    s3b = sat_add(s3a[63:0], prod[2]);
    // first multiply of each term
    if (job_q.cfg.norm_mode == NormLocal && job_q.cfg.quantity == QtyQ) begin
      mul_in = qpart_q ? prod[3] : s3b[63:0];
      mul_y  = qpart_q ? 64'(r2sum) : 64'(r2[3]);
      mul_s  = 5'd24;
    end else begin
      mul_in = prod[c_q];
      mul_y  = 64'(job_q.pt.cell_volume);
      mul_s  = 5'd8;
    end
    ma = mag64((state_q == S_MUL2) ? x_q : mul_in);
    mb = (state_q == S_MUL2) ? 64'(job_q.pt.cell_volume) : mul_y;
    msh = mp >> ((state_q == S_MUL2W) ? 5'd8 : mul_s);
    tv = to_signed(msh, (state_q == S_MUL2W) ? x_q[63] : mul_in[63]);
    if (state_q == S_FDIV || state_q == S_FDIVW) begin
      dm = mag64(comp_q[c_q]);
      dd = (c_q == 2'd3) ? 64'(avg[3]) : 64'(a2[c_q]);
      ds = (c_q == 2'd3) ? 5'd12 : 5'd24;
    end else begin
      dm = mag64(x_q);
      dd = 64'(r2[c_q]) + 64'(a2[c_q]);
      ds = 5'd24;
    end
    sv = to_signed(dq, (state_q == S_FDIVW) ? comp_q[c_q][63] : x_q[63]);
    av = sat_add(res_q, x_q);
    cv = sat_add(comp_q[c_q], x_q);
    fv = sat_add(total_q, res_q);
    rv = sat_add(res_q, (dd == 64'd0) ? 64'sd0 : sv[63:0]);
    mstart = (state_q == S_TERM) || (state_q == S_MUL2);
    dstart = (state_q == S_DIV && dd != 64'd0) || (state_q == S_FDIV && dd != 64'd0);
  end

  assign deq_o     = state_q == S_NEXT;
  assign out_s.valid = state_q == S_OUT;
  assign out_s.data  = '{dot_sum: res_q, saturated: flags_q[0],
                         zero_divisor: flags_q[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      flags_q <= '0;
      for (int i = 0; i < 4; i++) comp_q[i] <= '0;
      res_q   <= '0;
      c_q     <= '0;
      last_c_q <= '0;
      qpart_q <= 1'b0;
      x_q     <= '0;
      job_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            res_q   <= '0;
            qpart_q <= 1'b0;
            c_q     <= (job_i.cfg.quantity < QtyKe) ? job_i.cfg.quantity[1:0] : 2'd0;
            last_c_q <= (job_i.cfg.quantity < QtyKe) ? job_i.cfg.quantity[1:0] :
                        (job_i.cfg.quantity == QtyKe ? 2'd2 : 2'd3);
            // invalid combination at last point still emits zero
            if (job_i.valid_combo)
              state_q <= S_TERM;
            else if (job_i.pt.last_point)
              state_q <= S_OUT;
            else
              state_q <= S_NEXT;
          end
        end
        S_TERM: state_q <= S_MUL1W;
        S_MUL1W: begin
          if (mdone) begin
            x_q <= tv[63:0];
            if (tv[64]) flags_q[0] <= 1'b1;
            if (job_q.cfg.norm_mode == NormLocal && job_q.cfg.quantity == QtyQ)
              state_q <= S_MUL2;
            else if (job_q.cfg.norm_mode == NormLocal)
              state_q <= S_DIV;
            else
              state_q <= S_ADD;
          end
        end
        S_MUL2: state_q <= S_MUL2W;
        S_MUL2W: begin
          if (mdone) begin
            x_q <= tv[63:0];
            if (tv[64]) flags_q[0] <= 1'b1;
            state_q <= S_ADD;
          end
        end
        S_DIV: begin
          if (dd == 64'd0) begin
            flags_q[1] <= 1'b1;
            x_q <= '0;
            state_q <= S_ADD;
          end else begin
            state_q <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (ddone) begin
            x_q <= sv[63:0];
            if (sv[64]) flags_q[0] <= 1'b1;
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          // res_q holds the point's term; global adds to the component sum
          if (job_q.cfg.norm_mode == NormGlobal) begin
            comp_q[c_q] <= cv[63:0];
            if (cv[64]) flags_q[0] <= 1'b1;
          end else begin
            res_q <= av[63:0];
            if (av[64]) flags_q[0] <= 1'b1;
          end
          if (job_q.cfg.norm_mode == NormLocal && job_q.cfg.quantity == QtyQ) begin
            if (!qpart_q) begin
              qpart_q <= 1'b1;
              state_q <= S_TERM;
            end else begin
              state_q <= S_FIN;
            end
          end else if (c_q != last_c_q) begin
            c_q <= c_q + 2'd1;
            state_q <= S_TERM;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (job_q.cfg.norm_mode != NormGlobal) begin
            if (fv[64]) flags_q[0] <= 1'b1;
            if (job_q.pt.last_point) begin
              res_q   <= fv[63:0];
              state_q <= S_OUT;
            end else begin
              total_q <= fv[63:0];
              state_q <= S_NEXT;
            end
          end else if (job_q.pt.last_point) begin
            res_q   <= '0;
            c_q     <= '0;
            last_c_q <= (job_q.cfg.quantity == QtyQ) ? 2'd3 : 2'd2;
            state_q <= S_FDIV;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_FDIV: begin
          if (dd == 64'd0) begin
            flags_q[1] <= 1'b1;
            x_q <= '0;
            state_q <= S_FDIVW;
          end else begin
            state_q <= S_FDIVW;
          end
        end
        S_FDIVW: begin
          if (ddone || x_q == '0 && dd == 64'd0) begin
            res_q <= rv[63:0];
            if (rv[64] || (dd != 64'd0 && sv[64])) flags_q[0] <= 1'b1;
            if (c_q != last_c_q) begin
              c_q <= c_q + 2'd1;
              state_q <= S_FDIV;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_s.ready) begin
            total_q <= '0;
            flags_q <= '0;
            for (int i = 0; i < 4; i++) comp_q[i] <= '0;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && !out_s.ready |=> out_s.valid) else $error("result dropped");
  a_deq_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |=> !deq_o) else $error("double dequeue");
  a_out_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid |-> job_q.pt.last_point) else $error("result without last point");
`endif
endmodule

>>> verif/weighted_inner_product_accumulator_tb.sv
`timescale 1ns / 100ps

module weighted_inner_product_accumulator_tb;
  import wipa_pkg::*;

  localparam int unsigned StallCycles = 400;
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned TailCycles  = 1200;
  localparam int unsigned RandPoints  = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [CfgWidth-1:0] cfg_data_i;

  wipa_stream_if #(.T(point_t))  in_if ();
  wipa_stream_if #(.T(result_t)) out_if ();

  weighted_inner_product_accumulator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_if),
    .out_s      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor copy of the configuration and accumulation state
  logic [2:0]         cfg_qty;
  logic [1:0]         cfg_norm;
  logic               cfg_planar;
  logic [15:0]        cfg_avg [4];
  logic signed [63:0] acc_total;
  logic signed [63:0] acc_comp [4];
  logic [1:0]         acc_flags;

  result_t ip_expect_q [$];
  int unsigned pts_sent, n_sums, n_checked, n_fail;
  int unsigned idle_cnt;
  bit no_gaps;
  bit stall_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x < 0 ? 64'(64'd0 - 64'(x)) : 64'(x);
  endfunction

  function automatic logic signed [63:0] fit64(input logic [127:0] m, input logic neg);
    logic [63:0] top;
    top = 64'h8000_0000_0000_0000;
    if (m[127:64] != 64'd0 || m[63:0] > top || (!neg && m[63:0] == top)) begin
      acc_flags[0] = 1'b1;
      return neg ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end
    return neg ? $signed(64'(64'd0 - m[63:0])) : $signed(m[63:0]);
  endfunction

  function automatic logic signed [63:0] mul_trunc(input logic signed [63:0] x,
                                                   input logic [63:0] y, input int s);
    logic [127:0] m;
    m = 128'(abs64(x)) * 128'(y);
    return fit64(m >> s, x < 0);
  endfunction

  function automatic logic signed [63:0] div_trunc(input logic signed [63:0] x,
                                                   input logic [63:0] d, input int s);
    logic [127:0] num;
    if (d == 64'd0) begin
      acc_flags[1] = 1'b1;
      return 64'sd0;
    end
    num = 128'(abs64(x)) << s;
    return fit64(num / 128'(d), x < 0);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      acc_flags[0] = 1'b1;
      return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return $signed({{48{v[15]}}, v});
  endfunction

  task automatic predict_point(input point_t p, output bit got, output result_t r);
    logic signed [63:0] prod [4];
    logic [63:0] r2 [4];
    logic [63:0] a2 [4];
    logic [15:0] sa [4];
    logic [15:0] sb [4];
    logic [15:0] rv;
    logic [63:0] vol;
    logic signed [63:0] term, res, s3, x, y, tc;
    logic ok;
    int n, first;
    sa = '{p.a_u, p.a_v, p.a_w, p.a_p};
    sb = '{p.b_u, p.b_v, p.b_w, p.b_p};
    vol = {32'd0, p.cell_volume};
    for (int c = 0; c < 4; c++) begin
      rv = p.rms_packed[16*c +: 16];
      prod[c] = sx16(sa[c]) * sx16(sb[c]);
      r2[c] = 64'(rv) * 64'(rv);
      a2[c] = 64'(cfg_avg[c]) * 64'(cfg_avg[c]);
    end
    ok = cfg_qty <= QtyQ && cfg_norm <= NormGlobal && !(cfg_qty == QtyW && cfg_planar) &&
         !(cfg_norm == NormGlobal && cfg_qty < QtyKe);
    term = 0;
    res = 0;
    if (ok) begin
      n = cfg_qty < QtyKe ? 1 : (cfg_qty == QtyKe ? 3 : 4);
      first = cfg_qty < QtyKe ? int'(cfg_qty) : 0;
      if (cfg_norm == NormLocal && cfg_qty == QtyQ) begin
        // cross-weighted q: velocity part by rms_p^2, pressure by velocity rms^2
        s3 = add_sat(add_sat(prod[0], prod[1]), prod[2]);
        x = mul_trunc(mul_trunc(s3, r2[3], 24), vol, 8);
        y = mul_trunc(mul_trunc(prod[3], r2[0] + r2[1] + r2[2], 24), vol, 8);
        term = add_sat(x, y);
      end else begin
        for (int c = first; c < first + n; c++) begin
          tc = mul_trunc(prod[c], vol, 8);
          if (cfg_norm == NormNone) term = add_sat(term, tc);
          else if (cfg_norm == NormLocal) term = add_sat(term, div_trunc(tc, r2[c] + a2[c], 24));
          else acc_comp[c] = add_sat(acc_comp[c], tc);
        end
      end
      acc_total = add_sat(acc_total, term);
    end
    got = p.last_point;
    r = '0;
    if (!p.last_point) return;
    if (ok) begin
      if (cfg_norm == NormGlobal) begin
        for (int c = 0; c < 3; c++) res = add_sat(res, div_trunc(acc_comp[c], a2[c], 24));
        // p average is applied unsquared
        if (cfg_qty == QtyQ) res = add_sat(res, div_trunc(acc_comp[3], 64'(cfg_avg[3]), 12));
      end else begin
        res = acc_total;
      end
    end
    r.dot_sum = res;
    r.saturated = acc_flags[0];
    r.zero_divisor = acc_flags[1];
    acc_total = 0;
    for (int c = 0; c < 4; c++) acc_comp[c] = 0;
    acc_flags = 2'b00;
  endtask

  task automatic put_reg(input logic [CfgIdxWidth-1:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      RegQuantity: cfg_qty = val[2:0];
      RegNormMode: cfg_norm = val[1:0];
      RegPlanar:   cfg_planar = val[0];
      RegAvgU:     cfg_avg[0] = val;
      RegAvgV:     cfg_avg[1] = val;
      RegAvgW:     cfg_avg[2] = val;
      RegAvgP:     cfg_avg[3] = val;
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [2:0] qty, input logic [1:0] nm, input logic pl,
                            input logic [15:0] au, input logic [15:0] av,
                            input logic [15:0] aw, input logic [15:0] ap);
    put_reg(RegQuantity, 16'(qty));
    put_reg(RegNormMode, 16'(nm));
    put_reg(RegPlanar, 16'(pl));
    put_reg(RegAvgU, au);
    put_reg(RegAvgV, av);
    put_reg(RegAvgW, aw);
    put_reg(RegAvgP, ap);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (ip_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // typed_ok set: the row's expected result replaces the predicted one
  task automatic send_point(input point_t p, input bit typed_ok, input result_t typed_r);
    int unsigned gap;
    bit got;
    bit took;
    result_t r;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 2) == 0)
      gap = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= p;
    // ready only depends on queue fill, so mid-cycle sampling is safe
    do begin
      @(negedge clk_i);
      took = in_if.ready;
      @(posedge clk_i);
    end while (!took);
    pts_sent++;
    predict_point(p, got, r);
    if (got) begin
      n_sums++;
      ip_expect_q.push_back(typed_ok ? typed_r : r);
    end
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return AvgReset;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_volume();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2, 3: return 32'($urandom_range(0, 32'h20000));
      default: return $urandom;
    endcase
  endfunction

  function automatic point_t rand_point(input logic last);
    point_t p;
    p.a_u = pick_sample();
    p.a_v = pick_sample();
    p.a_w = pick_sample();
    p.a_p = pick_sample();
    p.b_u = pick_sample();
    p.b_v = pick_sample();
    p.b_w = pick_sample();
    p.b_p = pick_sample();
    p.rms_packed = {pick_scale(), pick_scale(), pick_scale(), pick_scale()};
    p.cell_volume = pick_volume();
    p.last_point = last;
    return p;
  endfunction

  function automatic point_t flat_point(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] rms, input logic [31:0] vol);
    point_t p;
    p.a_u = a; p.a_v = a; p.a_w = a; p.a_p = a;
    p.b_u = b; p.b_v = b; p.b_w = b; p.b_p = b;
    p.rms_packed = {4{rms}};
    p.cell_volume = vol;
    p.last_point = 1'b1;
    return p;
  endfunction

  typedef struct {
    logic [2:0]  qty;
    logic [1:0]  nm;
    logic        pl;
    logic [15:0] avg;
    point_t      pt;
    bit          typed_ok;
    result_t     want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic add_row(input logic [2:0] qty, input logic [1:0] nm, input logic pl,
                         input logic [15:0] avg, input point_t pt, input bit typed_ok,
                         input logic [63:0] ip, input logic sat, input logic zd);
    dir_row_t d;
    d.qty = qty; d.nm = nm; d.pl = pl; d.avg = avg; d.pt = pt;
    d.typed_ok = typed_ok;
    d.want.dot_sum = ip;
    d.want.saturated = sat;
    d.want.zero_divisor = zd;
    dir_rows.push_back(d);
  endtask

  // scoreboard
  always @(posedge clk_i) begin
    result_t w;
    if (out_if.valid && out_if.ready) begin
      if (ip_expect_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_if.data);
        n_fail++;
      end else begin
        w = ip_expect_q.pop_front();
        n_checked++;
        if (out_if.data.dot_sum !== w.dot_sum) begin
          $error("dot_sum expected %h got %h", w.dot_sum, out_if.data.dot_sum);
          n_fail++;
        end
        if (out_if.data.saturated !== w.saturated) begin
          $error("saturated expected %b got %b", w.saturated, out_if.data.saturated);
          n_fail++;
        end
        if (out_if.data.zero_divisor !== w.zero_divisor) begin
          $error("zero_divisor expected %b got %b", w.zero_divisor, out_if.data.zero_divisor);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles", IdleLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
      end else if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 5) == 0)
          hold = $urandom_range(0, 9) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 3);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [2:0]  qty;
    logic [1:0]  nm;
    int unsigned len, phase;
    result_t none_r;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    no_gaps = 1'b0;
    stall_req = 1'b0;
    idle_cnt = 0;
    pts_sent = 0; n_sums = 0; n_checked = 0; n_fail = 0;
    none_r = '0;
    cfg_qty = QtyU; cfg_norm = NormNone; cfg_planar = 1'b0;
    for (int c = 0; c < 4; c++) begin
      cfg_avg[c] = AvgReset;
      acc_comp[c] = 0;
    end
    acc_total = 0;
    acc_flags = 2'b00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // first beat under reset configuration: 1.0 * 1.0 * 1.0
    send_point(flat_point(16'h1000, 16'h1000, 16'h1000, 32'h0001_0000), 1'b1,
               '{dot_sum: 64'h1_0000_0000, saturated: 1'b0, zero_divisor: 1'b0});
    in_if.valid <= 1'b0;
    drain();

    add_row(QtyW, NormNone, 1'b1, AvgReset, flat_point(16'h7fff, 16'h7fff, 16'h1000,
            32'hffff_ffff), 1'b1, 64'd0, 1'b0, 1'b0);
    add_row(3'd6, NormNone, 1'b0, AvgReset, flat_point(16'h1234, 16'h4321, 16'h1000,
            32'h0001_0000), 1'b1, 64'd0, 1'b0, 1'b0);
    add_row(3'd7, NormLocal, 1'b0, AvgReset, flat_point(16'h8000, 16'h8000, 16'h1000,
            32'h0001_0000), 1'b1, 64'd0, 1'b0, 1'b0);
    add_row(QtyKe, 2'd3, 1'b0, AvgReset, flat_point(16'h1000, 16'h1000, 16'h1000,
            32'h0001_0000), 1'b1, 64'd0, 1'b0, 1'b0);
    add_row(QtyP, NormGlobal, 1'b0, AvgReset, flat_point(16'h1000, 16'h1000, 16'h1000,
            32'h0001_0000), 1'b1, 64'd0, 1'b0, 1'b0);
    // zero divisor: rms and average both zero
    add_row(QtyU, NormLocal, 1'b0, 16'h0000, flat_point(16'h1000, 16'h1000, 16'h0000,
            32'h0001_0000), 1'b1, 64'd0, 1'b0, 1'b1);
    add_row(QtyKe, NormGlobal, 1'b0, 16'h0000, flat_point(16'h1000, 16'h1000, 16'h1000,
            32'h0001_0000), 1'b1, 64'd0, 1'b0, 1'b1);
    add_row(QtyP, NormNone, 1'b0, AvgReset, flat_point(16'h7fff, 16'h8000, 16'hffff,
            32'd0), 1'b1, 64'd0, 1'b0, 1'b0);
    add_row(QtyKe, NormNone, 1'b0, AvgReset, flat_point(16'h8000, 16'h8000, 16'hffff,
            32'hffff_ffff), 1'b0, 64'd0, 1'b0, 1'b0);
    add_row(QtyQ, NormNone, 1'b1, AvgReset, flat_point(16'h7fff, 16'h8000, 16'hffff,
            32'hffff_ffff), 1'b0, 64'd0, 1'b0, 1'b0);
    add_row(QtyV, NormLocal, 1'b0, 16'hffff, flat_point(16'h8000, 16'h7fff, 16'hffff,
            32'hffff_ffff), 1'b0, 64'd0, 1'b0, 1'b0);
    add_row(QtyP, NormLocal, 1'b0, 16'h0001, flat_point(16'h8000, 16'h8000, 16'h0000,
            32'hffff_ffff), 1'b0, 64'd0, 1'b0, 1'b0);
    add_row(QtyKe, NormLocal, 1'b1, 16'h1000, flat_point(16'h7fff, 16'h7fff, 16'h0001,
            32'h0001_0000), 1'b0, 64'd0, 1'b0, 1'b0);
    // q local saturates after the volume factor
    add_row(QtyQ, NormLocal, 1'b0, 16'hffff, flat_point(16'h8000, 16'h8000, 16'hffff,
            32'hffff_ffff), 1'b0, 64'd0, 1'b0, 1'b0);
    add_row(QtyQ, NormGlobal, 1'b0, 16'h0001, flat_point(16'h8000, 16'h8000, 16'hffff,
            32'hffff_ffff), 1'b0, 64'd0, 1'b0, 1'b0);
    add_row(QtyKe, NormGlobal, 1'b1, 16'hffff, flat_point(16'h7fff, 16'h8000, 16'h1000,
            32'h0123_4567), 1'b0, 64'd0, 1'b0, 1'b0);
    add_row(QtyQ, NormGlobal, 1'b0, 16'h0000, flat_point(16'h1000, 16'h1000, 16'h1000,
            32'h0001_0000), 1'b1, 64'd0, 1'b0, 1'b1);

    foreach (dir_rows[i]) begin
      load_setup(dir_rows[i].qty, dir_rows[i].nm, dir_rows[i].pl, dir_rows[i].avg,
                 dir_rows[i].avg, dir_rows[i].avg, dir_rows[i].avg);
      send_point(dir_rows[i].pt, dir_rows[i].typed_ok, dir_rows[i].want);
      in_if.valid <= 1'b0;
      drain();
    end

    phase = 0;
    while (pts_sent < RandPoints + dir_rows.size() + 1) begin
      nm = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      qty = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if (nm == NormGlobal && $urandom_range(0, 9) < 8) qty = 3'($urandom_range(4, 5));
      load_setup(qty, nm, 1'($urandom), pick_scale(), pick_scale(), pick_scale(),
                 pick_scale());
      no_gaps = $urandom_range(0, 4) == 0;
      if (phase == 3) begin
        // hold the result side while points keep coming
        no_gaps = 1'b1;
        stall_req = 1'b1;
        for (int k = 0; k < 6; k++) send_point(rand_point(1'b1), 1'b0, none_r);
      end else begin
        for (int s = 0, ns = $urandom_range(1, 4); s < ns; s++) begin
          len = $urandom_range(0, 7) == 0 ? $urandom_range(6, 10) : $urandom_range(1, 4);
          for (int k = 1; k <= len; k++) send_point(rand_point(k == len), 1'b0, none_r);
        end
      end
      in_if.valid <= 1'b0;
      drain();
      phase++;
    end

    while (ip_expect_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("%0d points in %0d sums over %0d setups, %0d results compared",
             pts_sent, n_sums, phase + dir_rows.size() + 1, n_checked);
    $display("covered all quantities, norm modes, planar data, bad combos and saturation");
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
